@@ rtl/emt_pkg.sv @@
package emt_pkg;

    localparam int NUM_STATES_DEF   = 4;
    localparam int NUM_CONTROLS_DEF = 2;
    localparam int MAX_NODES_DEF    = 256;
    localparam int MAX_REGIONS_DEF  = 128;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int IN_STATES = 4;
    localparam int PROD_W    = 64;
    localparam int ACC_W     = 80;

    localparam logic [2:0] REQ_COEFF  = 3'd0;
    localparam logic [2:0] REQ_NODE   = 3'd1;
    localparam logic [2:0] REQ_GAIN   = 3'd2;
    localparam logic [2:0] REQ_GOFF   = 3'd3;
    localparam logic [2:0] REQ_EVAL   = 3'd4;

    localparam logic REG_STATES   = 1'b0;
    localparam logic REG_CONTROLS = 1'b1;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [7:0]         table_index;
        logic [1:0]         element_index;
        logic               control_index;
        logic signed [31:0] load_value;
        logic [8:0]         left_link;
        logic [8:0]         right_link;
        logic [6:0]         leaf_region;
        logic signed [31:0] state_0;
        logic signed [31:0] state_1;
        logic signed [31:0] state_2;
        logic signed [31:0] state_3;
    } req_t;

    typedef struct packed {
        logic [6:0]         region;
        logic               action_index;
        logic signed [31:0] control_value;
        logic               walk_error;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] data;
    } cfg_t;

endpackage

@@ rtl/emt_lane.sv @@
module emt_lane
(
    input  logic               clk,
    input  logic signed [31:0] coef,
    input  logic signed [31:0] xval,
    input  logic               use_lane,
    output logic signed [63:0] prod
);
    import emt_pkg::*;

    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_next;

    assign prod_next = use_lane ? coef * xval : 64'sd0;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;
endmodule

@@ rtl/emt_merge.sv @@
module emt_merge #(
    parameter int NUM_STATES = emt_pkg::NUM_STATES_DEF,
    parameter int FRAC_BITS  = emt_pkg::FRAC_BITS_DEF
)
(
    input  logic                             clk,
    input  logic signed [NUM_STATES-1:0][63:0] prods,
    input  logic signed [31:0]               offset,
    input  logic                             sub_offset,
    output logic signed [emt_pkg::ACC_W-1:0] sum
);
    import emt_pkg::*;

    logic signed [ACC_W-1:0] sum_reg;
    logic signed [ACC_W-1:0] sum_next;
    logic signed [ACC_W-1:0] off_ext;

    always_comb
    begin
        off_ext = ACC_W'(offset) <<< FRAC_BITS;
        sum_next = sub_offset ? -off_ext : off_ext;
        for (int i = 0; i < NUM_STATES; i++)
        begin
            sum_next = sum_next + ACC_W'($signed(prods[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign sum = sum_reg;
endmodule

@@ rtl/explicit_mpc_tree_control_law.sv @@
// Explicit MPC law evaluated by a hyperplane tree.
// Requests enter on req (valid/ready). Load requests (types 0..3) write the
// node and region tables when taken and give no response; loads can be
// taken every cycle while the engine is idle. An evaluate request walks the
// tree from node 0 with a table read, lane multiply, merge and decide step
// per decision node and a read and leaf check for the leaf, then forms one
// response per control by read, multiply, merge, saturate and output steps.
// The engine takes no new request until the last response of an evaluate
// has gone into the output register.
// Responses leave on rsp (valid/ready) through an output register; while
// the receiver stalls the engine waits with the next result.
// Configuration writes on cfg (valid/ready) set states_in_use and
// controls_in_use; they are taken any time and must only be sent when idle.
// Reset returns the registers to 4 and 2 and the engine to idle; the tables
// hold garbage until loaded and need no clearing.
// A walk that reaches MAX_NODES decision nodes or follows a bad link gives a
// single response with walk_error set.
module explicit_mpc_tree_control_law #(
    parameter int NUM_STATES   = emt_pkg::NUM_STATES_DEF,
    parameter int NUM_CONTROLS = emt_pkg::NUM_CONTROLS_DEF,
    parameter int MAX_NODES    = emt_pkg::MAX_NODES_DEF,
    parameter int MAX_REGIONS  = emt_pkg::MAX_REGIONS_DEF,
    parameter int FRAC_BITS    = emt_pkg::FRAC_BITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  emt_pkg::req_t   req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output emt_pkg::rsp_t   rsp,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  emt_pkg::cfg_t   cfg
);
    import emt_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int RW  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int SW  = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int CW  = (NUM_CONTROLS > 1) ? $clog2(NUM_CONTROLS) : 1;
    localparam int VW  = $clog2(MAX_NODES + 1);
    localparam int LW  = 9;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_MUL   = 6'b000100,
        S_SUM   = 6'b001000,
        S_DEC   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0] states_in_use_reg;
    logic [1:0] controls_in_use_reg;
    logic [3:0] ns;
    logic [3:0] nc;

    logic signed [31:0] coef_mem [MAX_NODES][NUM_STATES];
    logic signed [31:0] noff_mem [MAX_NODES];
    logic [LW-1:0]      left_mem [MAX_NODES];
    logic [LW-1:0]      right_mem [MAX_NODES];
    logic [6:0]         leaf_mem [MAX_NODES];
    logic signed [31:0] gain_mem [MAX_REGIONS*NUM_CONTROLS][NUM_STATES];
    logic signed [31:0] goff_mem [MAX_REGIONS*NUM_CONTROLS];

    logic signed [31:0] coef_rd [NUM_STATES];
    logic signed [31:0] gain_rd [NUM_STATES];
    logic signed [31:0] noff_rd, goff_rd;
    logic [LW-1:0]      left_rd, right_rd;
    logic [6:0]         leaf_rd;

    logic signed [31:0] x_reg [NUM_STATES];
    logic [NW-1:0]      node_reg;
    logic [VW-1:0]      visits_reg;
    logic               phase_out_reg;
    logic [CW-1:0]      ctl_reg;
    logic [6:0]         region_reg;

    logic               rsp_valid_reg;
    rsp_t               rsp_reg;
    rsp_t               res_reg;
    logic               load_out;

    logic signed [NUM_STATES-1:0][63:0] prods;
    logic signed [ACC_W-1:0]            sum;
    logic                               in_range;

    logic               accept;
    logic [RW+CW-1:0]   gaddr;
    logic signed [31:0] x_in [IN_STATES];

    assign cfg_ready = 1'b1;
    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign load_out  = (state_reg == S_OUT) && (!rsp_valid_reg || rsp_ready);

    assign x_in[0] = req.state_0;
    assign x_in[1] = req.state_1;
    assign x_in[2] = req.state_2;
    assign x_in[3] = req.state_3;

    always_comb
    begin
        ns = {1'b0, states_in_use_reg};
        if (ns < 4'd1) ns = 4'd1;
        if (ns > 4'(NUM_STATES)) ns = 4'(NUM_STATES);
        nc = {2'b0, controls_in_use_reg};
        if (nc < 4'd1) nc = 4'd1;
        if (nc > 4'(NUM_CONTROLS)) nc = 4'(NUM_CONTROLS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            states_in_use_reg   <= 3'd4;
            controls_in_use_reg <= 2'd2;
        end
        else if (cfg_valid)
        begin
            if (cfg.index == {1'b0, REG_STATES})
                states_in_use_reg <= cfg.data[2:0];
            else if (cfg.index == {1'b0, REG_CONTROLS})
                controls_in_use_reg <= cfg.data[1:0];
        end
    end

    // table writes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (req.req_type == REQ_COEFF && 32'(req.table_index) < MAX_NODES
                && 32'(req.element_index) < NUM_STATES)
                coef_mem[NW'(req.table_index)][SW'(req.element_index)] <= req.load_value;
            if (req.req_type == REQ_NODE && 32'(req.table_index) < MAX_NODES)
            begin
                noff_mem[NW'(req.table_index)]  <= req.load_value;
                left_mem[NW'(req.table_index)]  <= req.left_link;
                right_mem[NW'(req.table_index)] <= req.right_link;
                leaf_mem[NW'(req.table_index)]  <= req.leaf_region;
            end
            if (req.req_type == REQ_GAIN && 32'(req.table_index) < MAX_REGIONS
                && 32'(req.control_index) < NUM_CONTROLS
                && 32'(req.element_index) < NUM_STATES)
                gain_mem[(RW+CW)'(32'(req.table_index) * NUM_CONTROLS
                    + 32'(req.control_index))][SW'(req.element_index)] <= req.load_value;
            if (req.req_type == REQ_GOFF && 32'(req.table_index) < MAX_REGIONS
                && 32'(req.control_index) < NUM_CONTROLS)
                goff_mem[(RW+CW)'(32'(req.table_index) * NUM_CONTROLS
                    + 32'(req.control_index))] <= req.load_value;
        end
    end

    assign gaddr    = (RW+CW)'(32'(region_reg) * NUM_CONTROLS + 32'(ctl_reg));
    assign in_range = 32'(region_reg) < MAX_REGIONS;

    // registered table reads
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            for (int i = 0; i < NUM_STATES; i++)
            begin
                coef_rd[i] <= coef_mem[node_reg][i];
                gain_rd[i] <= gain_mem[gaddr][i];
            end
            noff_rd  <= noff_mem[node_reg];
            goff_rd  <= goff_mem[gaddr];
            left_rd  <= left_mem[node_reg];
            right_rd <= right_mem[node_reg];
            leaf_rd  <= leaf_mem[node_reg];
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_STATES; g++)
        begin : g_lane
            emt_lane u_lane (
                .clk      (clk),
                .coef     (phase_out_reg ? gain_rd[g] : coef_rd[g]),
                .xval     (x_reg[g]),
                .use_lane (4'(g) < ns),
                .prod     (prods[g])
            );
        end
    endgenerate

    emt_merge #(
        .NUM_STATES (NUM_STATES),
        .FRAC_BITS  (FRAC_BITS)
    ) u_merge (
        .clk        (clk),
        .prods      (prods),
        .offset     (phase_out_reg ? goff_rd : noff_rd),
        .sub_offset (!phase_out_reg),
        .sum        (sum)
    );

    // saturation of the Q.2F sum to 32 bits
    logic signed [ACC_W-1:0] shifted;
    logic signed [31:0]      sat;
    assign shifted = sum >>> FRAC_BITS;
    always_comb
    begin
        if (shifted > ACC_W'(64'sh7FFFFFFF))
            sat = 32'sh7FFFFFFF;
        else if (shifted < -ACC_W'(64'sh80000000))
            sat = -32'sh80000000;
        else
            sat = shifted[31:0];
    end

    logic [LW-1:0] link;
    assign link = (sum <= 0) ? left_rd : right_rd;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept && req.req_type == REQ_EVAL) state_next = S_READ;
            S_READ: state_next = S_MUL;
            S_MUL:  state_next = (!phase_out_reg && left_rd == '0) ? S_READ : S_SUM;
            S_SUM:  state_next = S_DEC;
            S_DEC:
            begin
                if (phase_out_reg)
                    state_next = S_OUT;
                else if (link == '0 || 32'(link) > MAX_NODES
                         || 32'(visits_reg) + 1 >= MAX_NODES)
                    state_next = S_OUT;
                else
                    state_next = S_READ;
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    if (res_reg.last)
                        state_next = S_IDLE;
                    else
                        state_next = S_READ;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_out_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            visits_reg    <= '0;
            node_reg      <= '0;
            ctl_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    node_reg      <= '0;
                    visits_reg    <= '0;
                    ctl_reg       <= '0;
                    phase_out_reg <= 1'b0;
                end
                S_READ:
                begin
                end
                S_MUL:
                begin
                    if (!phase_out_reg && left_rd == '0)
                    begin
                        phase_out_reg <= 1'b1;
                        region_reg    <= leaf_rd;
                    end
                end
                S_SUM:
                begin
                end
                S_DEC:
                begin
                    if (phase_out_reg)
                    begin
                        res_reg.region        <= region_reg;
                        res_reg.action_index  <= ctl_reg[0];
                        res_reg.control_value <= in_range ? sat : 32'sd0;
                        res_reg.walk_error    <= 1'b0;
                        res_reg.last          <= (4'(ctl_reg) + 4'd1 == nc);
                    end
                    else if (link == '0 || 32'(link) > MAX_NODES
                             || 32'(visits_reg) + 1 >= MAX_NODES)
                    begin
                        res_reg.region        <= '0;
                        res_reg.action_index  <= 1'b0;
                        res_reg.control_value <= '0;
                        res_reg.walk_error    <= 1'b1;
                        res_reg.last          <= 1'b1;
                    end
                    else
                    begin
                        node_reg   <= NW'(link - LW'(1));
                        visits_reg <= visits_reg + VW'(1);
                    end
                end
                S_OUT:
                begin
                    if (load_out)
                    begin
                        rsp_reg <= res_reg;
                        ctl_reg <= ctl_reg + CW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // region_reg and rsp_reg payload are not reset
    always_ff @(posedge clk)
    begin
        if (accept && req.req_type == REQ_EVAL)
        begin
            for (int i = 0; i < NUM_STATES; i++)
            begin
                x_reg[i] <= (i < IN_STATES) ? x_in[i % IN_STATES] : 32'sd0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_idle_no_rsp_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && rsp_valid_reg && !rsp_ready) |=> (state_reg == S_OUT))
        else $error("engine left output state while response stalled");
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.walk_error) |-> rsp_reg.last)
        else $error("walk error response not marked last");
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req_ready)
        else $error("request taken while busy");
endmodule

@@ verif/explicit_mpc_tree_control_law_tb.sv @@
`timescale 1ns / 100ps

module explicit_mpc_tree_control_law_tb;
    import emt_pkg::*;

    localparam int NS   = NUM_STATES_DEF;
    localparam int NC   = NUM_CONTROLS_DEF;
    localparam int MAXN = MAX_NODES_DEF;
    localparam int MAXR = MAX_REGIONS_DEF;
    localparam int FB   = FRAC_BITS_DEF;
    localparam int REQ_W = $bits(req_t);
    localparam int HOLD_LEN = 400;
    localparam logic [1:0] CFG_STATES   = {1'b0, REG_STATES};
    localparam logic [1:0] CFG_CONTROLS = {1'b0, REG_CONTROLS};
    localparam logic [1:0] CFG_SPARE    = 2'd2;
    localparam logic [2:0] REQ_BAD_LO   = 3'd5;
    localparam logic [2:0] REQ_BAD_HI   = 3'd7;

    typedef struct {
        req_t r;
        int   n_typed;
        rsp_t e0;
        rsp_t e1;
    } drow_t;

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_ready;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_ready;
    rsp_t  rsp;
    logic  cfg_valid;
    logic  cfg_ready;
    cfg_t  cfg;

    int         coef[MAXN*NS];
    bit         coef_w[MAXN*NS];
    int         noff[MAXN];
    logic [8:0] lft[MAXN];
    logic [8:0] rgt[MAXN];
    logic [6:0] lreg[MAXN];
    bit         node_w[MAXN];
    int         gain[MAXR*NC*NS];
    bit         gain_w[MAXR*NC*NS];
    int         goff[MAXR*NC];
    bit         goff_w[MAXR*NC];
    int         n_states = 4;
    int         n_ctrls = 2;

    rsp_t  law_q[$];
    drow_t dir_rows[$];
    int    errors = 0;
    int    send_idle = 0;
    int    recv_stall = 0;
    bit    hold_on = 1'b0;
    int    n_sent = 0;

    explicit_mpc_tree_control_law i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #60000000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic logic signed [79:0] prod(input int a, input int b);
        logic signed [79:0] p;
        p = longint'(a) * longint'(b);
        return p;
    endfunction

    function automatic int eff_states();
        int v;
        v = n_states & 7;
        if (v < 1) v = 1;
        if (v > NS) v = NS;
        return v;
    endfunction

    function automatic int eff_ctrls();
        int v;
        v = n_ctrls & 3;
        if (v < 1) v = 1;
        if (v > NC) v = NC;
        return v;
    endfunction

    // returns leaf node, or -1 on a failed walk; clean drops on any unwritten read
    function automatic int walk_tree(input req_t r, output bit clean);
        int node;
        int link;
        int ns;
        int xs[4];
        logic signed [79:0] acc;
        ns = eff_states();
        xs = '{r.state_0, r.state_1, r.state_2, r.state_3};
        node = 0;
        clean = 1'b1;
        for (int v = 0; v < MAXN; v++)
        begin
            if (!node_w[node])
            begin
                clean = 1'b0;
                return -1;
            end
            if (lft[node] == 0) return node;
            acc = -prod(noff[node], 1 << FB);
            for (int k = 0; k < ns; k++)
            begin
                if (!coef_w[node*NS+k]) clean = 1'b0;
                acc = acc + prod(coef[node*NS+k], xs[k]);
            end
            link = (acc <= 0) ? lft[node] : rgt[node];
            if (link == 0 || link > MAXN) return -1;
            node = link - 1;
        end
        return -1;
    endfunction

    function automatic bit eval_clean(input req_t r);
        bit clean;
        int leaf;
        int rg;
        leaf = walk_tree(r, clean);
        if (!clean) return 1'b0;
        if (leaf < 0) return 1'b1;
        rg = lreg[leaf];
        for (int j = 0; j < eff_ctrls(); j++)
        begin
            if (!goff_w[rg*NC+j]) return 1'b0;
            for (int k = 0; k < eff_states(); k++)
                if (!gain_w[(rg*NC+j)*NS+k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_law(input req_t r);
        bit clean;
        int leaf;
        int rg;
        int nc;
        int xs[4];
        logic signed [79:0] acc;
        logic signed [79:0] q;
        rsp_t e;
        case (r.req_type)
            REQ_COEFF:
            begin
                coef[r.table_index*NS+r.element_index] = r.load_value;
                coef_w[r.table_index*NS+r.element_index] = 1'b1;
            end
            REQ_NODE:
            begin
                noff[r.table_index] = r.load_value;
                lft[r.table_index] = r.left_link;
                rgt[r.table_index] = r.right_link;
                lreg[r.table_index] = r.leaf_region;
                node_w[r.table_index] = 1'b1;
            end
            REQ_GAIN:
                if (r.table_index < MAXR)
                begin
                    gain[(r.table_index*NC+r.control_index)*NS+r.element_index] = r.load_value;
                    gain_w[(r.table_index*NC+r.control_index)*NS+r.element_index] = 1'b1;
                end
            REQ_GOFF:
                if (r.table_index < MAXR)
                begin
                    goff[r.table_index*NC+r.control_index] = r.load_value;
                    goff_w[r.table_index*NC+r.control_index] = 1'b1;
                end
            REQ_EVAL:
            begin
                leaf = walk_tree(r, clean);
                if (leaf < 0)
                begin
                    e = '0;
                    e.walk_error = 1'b1;
                    e.last = 1'b1;
                    law_q.insert(law_q.size(), e);
                end
                else
                begin
                    rg = lreg[leaf];
                    nc = eff_ctrls();
                    xs = '{r.state_0, r.state_1, r.state_2, r.state_3};
                    for (int j = 0; j < nc; j++)
                    begin
                        acc = prod(goff[rg*NC+j], 1 << FB);
                        for (int k = 0; k < eff_states(); k++)
                            acc = acc + prod(gain[(rg*NC+j)*NS+k], xs[k]);
                        q = acc >>> FB;
                        e.region = rg[6:0];
                        e.action_index = j[0];
                        if (q > 80'sd2147483647)
                            e.control_value = 32'sh7FFFFFFF;
                        else if (q < -80'sd2147483648)
                            e.control_value = 32'sh80000000;
                        else
                            e.control_value = q[31:0];
                        e.walk_error = 1'b0;
                        e.last = (j == nc - 1);
                        law_q.insert(law_q.size(), e);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 262143)) - 131072;
            2:
                case ($urandom_range(4))
                    0: return 32'sh7FFFFFFF;
                    1: return 32'sh80000000;
                    2: return 0;
                    3: return 1;
                    default: return -1;
                endcase
            default: return $signed($urandom_range(0, 33554431)) - 16777216;
        endcase
    endfunction

    function automatic req_t rand_req(input logic [2:0] tp);
        req_t r;
        r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        r.req_type = tp;
        return r;
    endfunction

    function automatic req_t mk_load(input logic [2:0] tp, input int tix, input int eix,
                                     input int cix, input logic signed [31:0] val);
        req_t r;
        r = rand_req(tp);
        r.table_index = 8'(tix);
        r.element_index = 2'(eix);
        r.control_index = 1'(cix);
        r.load_value = val;
        return r;
    endfunction

    function automatic req_t mk_node(input int tix, input logic signed [31:0] off,
                                     input int l, input int rl, input int rg);
        req_t r;
        r = mk_load(REQ_NODE, tix, 0, 0, off);
        r.left_link = 9'(l);
        r.right_link = 9'(rl);
        r.leaf_region = 7'(rg);
        return r;
    endfunction

    function automatic req_t mk_eval(input logic signed [31:0] s0, input logic signed [31:0] s1,
                                     input logic signed [31:0] s2, input logic signed [31:0] s3);
        req_t r;
        r = rand_req(REQ_EVAL);
        r.state_0 = s0;
        r.state_1 = s1;
        r.state_2 = s2;
        r.state_3 = s3;
        return r;
    endfunction

    function automatic rsp_t mk_rsp(input int rg, input int ai, input logic signed [31:0] v,
                                    input bit err, input bit lst);
        rsp_t e;
        e.region = 7'(rg);
        e.action_index = 1'(ai);
        e.control_value = v;
        e.walk_error = err;
        e.last = lst;
        return e;
    endfunction

    function automatic void add_row(input req_t r, input int n, input rsp_t e0, input rsp_t e1);
        drow_t d;
        d.r = r;
        d.n_typed = n;
        d.e0 = e0;
        d.e1 = e1;
        dir_rows.insert(dir_rows.size(), d);
    endfunction

    task automatic send_req(input req_t r);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic send_item(input req_t r);
        send_req(r);
        predict_law(r);
        n_sent++;
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg <= '{index: idx, data: data};
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_STATES) n_states = data & 7;
        else if (idx == CFG_CONTROLS) n_ctrls = data & 3;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (law_q.size() > 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic load_region(input int rg);
        for (int c = 0; c < NC; c++)
        begin
            for (int k = 0; k < NS; k++)
                send_item(mk_load(REQ_GAIN, rg, k, c, rand_q()));
            send_item(mk_load(REQ_GOFF, rg, 0, c, rand_q()));
        end
    endtask

    // heap-ordered tree: node i has 1-based children 2i+2 and 2i+3, with an occasional bad right link
    task automatic build_tree();
        int depth;
        int n_int;
        int n_all;
        int rl;
        int rg;
        depth = ($urandom_range(9) == 0) ? 4 : $urandom_range(1, 3);
        n_int = (1 << depth) - 1;
        n_all = (1 << (depth + 1)) - 1;
        for (int i = 0; i < n_int; i++)
        begin
            for (int k = 0; k < NS; k++)
                send_item(mk_load(REQ_COEFF, i, k, 0, rand_q()));
            rl = 2*i + 3;
            if ($urandom_range(19) == 0)
                rl = $urandom_range(1) ? 0 : $urandom_range(257, 511);
            send_item(mk_node(i, rand_q(), 2*i + 2, rl, $urandom_range(127)));
        end
        for (int i = n_int; i < n_all; i++)
        begin
            rg = $urandom_range(127);
            send_item(mk_node(i, rand_q(), 0, $urandom_range(511), rg));
            load_region(rg);
        end
    endtask

    // builds a tree, then mixes requests until n_items requests have gone out
    task automatic run_random(input int n_items);
        int p;
        int tries;
        int start;
        req_t r;
        start = n_sent;
        build_tree();
        while (n_sent - start < n_items)
        begin
            p = $urandom_range(99);
            if (p < 70)
            begin
                tries = 0;
                do
                begin
                    r = mk_eval(rand_q(), rand_q(), rand_q(), rand_q());
                    tries++;
                end
                while (!eval_clean(r) && tries < 20);
                if (eval_clean(r))
                    send_item(r);
                else
                    build_tree();
            end
            else if (p < 90)
                send_item(mk_load(3'($urandom_range(REQ_COEFF, REQ_GOFF)), $urandom_range(255),
                                  $urandom_range(3), $urandom_range(1), rand_q()));
            else
                send_item(rand_req(3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI))));
        end
    endtask

    initial
    begin
        int held;
        held = 0;
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_on && held < HOLD_LEN)
            begin
                rsp_ready <= 1'b0;
                held++;
            end
            else
                rsp_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    initial
    begin
        rsp_t e;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
            begin
                if (law_q.size() == 0)
                    report_mismatch($sformatf("unexpected response %p", rsp));
                else
                begin
                    e = law_q.pop_front();
                    if (rsp.region !== e.region)
                        report_mismatch($sformatf("region %0d exp %0d", rsp.region, e.region));
                    if (rsp.action_index !== e.action_index)
                        report_mismatch($sformatf("action_index %0d exp %0d",
                                                  rsp.action_index, e.action_index));
                    if (rsp.control_value !== e.control_value)
                        report_mismatch($sformatf("control_value %h exp %h",
                                                  rsp.control_value, e.control_value));
                    if (rsp.walk_error !== e.walk_error)
                        report_mismatch($sformatf("walk_error %0d exp %0d",
                                                  rsp.walk_error, e.walk_error));
                    if (rsp.last !== e.last)
                        report_mismatch($sformatf("last %0d exp %0d", rsp.last, e.last));
                end
            end
        end
    end

    initial
    begin
        rsp_t none;
        rsp_t err;
        none = '0;
        err = mk_rsp(0, 0, 0, 1'b1, 1'b1);
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg = '0;

        // single leaf at the root, region 5; gains chosen to saturate both ways
        add_row(mk_node(0, 0, 0, 0, 5), 0, none, none);
        add_row(mk_load(REQ_GOFF, 5, 0, 0, 32'sh00010000), 0, none, none);
        add_row(mk_load(REQ_GOFF, 5, 0, 1, 32'sh80000000), 0, none, none);
        for (int c = 0; c < NC; c++)
            for (int k = 0; k < NS; k++)
                add_row(mk_load(REQ_GAIN, 5, k, c,
                                (k != 0) ? 32'sh0 : (c == 0) ? 32'sh7FFFFFFF : 32'sh80000000),
                        0, none, none);
        add_row(mk_eval(0, 0, 0, 0), 2, mk_rsp(5, 0, 32'sh00010000, 0, 0),
                mk_rsp(5, 1, 32'sh80000000, 0, 1));
        add_row(mk_eval(32'sh7FFFFFFF, 0, 0, 0), 2, mk_rsp(5, 0, 32'sh7FFFFFFF, 0, 0),
                mk_rsp(5, 1, 32'sh80000000, 0, 1));
        add_row(mk_eval(32'sh80000000, 0, 0, 0), 2, mk_rsp(5, 0, 32'sh80000000, 0, 0),
                mk_rsp(5, 1, 32'sh7FFFFFFF, 0, 1));
        // root splits on state_0; right link 0 is a failed walk
        add_row(mk_node(0, 0, 2, 0, 0), 0, none, none);
        add_row(mk_node(1, 0, 0, 0, 5), 0, none, none);
        for (int k = 0; k < NS; k++)
            add_row(mk_load(REQ_COEFF, 0, k, 0, (k == 0) ? 32'sh00010000 : 32'sh0),
                    0, none, none);
        add_row(mk_eval(1, 0, 0, 0), 1, err, none);
        add_row(mk_eval(-1, 5, -7, 9), 0, none, none);
        add_row(mk_eval(0, 0, 0, 0), 2, mk_rsp(5, 0, 32'sh00010000, 0, 0),
                mk_rsp(5, 1, 32'sh80000000, 0, 1));
        // link past the last node, then a loop on the root
        add_row(mk_node(0, 0, 2, 257, 0), 0, none, none);
        add_row(mk_eval(32'sh00050000, 0, 0, 0), 1, err, none);
        add_row(mk_node(0, 0, 1, 1, 0), 0, none, none);
        add_row(mk_eval(3, 0, 0, 0), 1, err, none);
        add_row(rand_req(REQ_BAD_HI), 0, none, none);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            send_req(dir_rows[i].r);
            if (dir_rows[i].n_typed > 0)
            begin
                law_q.insert(law_q.size(), dir_rows[i].e0);
                if (dir_rows[i].n_typed > 1) law_q.insert(law_q.size(), dir_rows[i].e1);
            end
            else
                predict_law(dir_rows[i].r);
        end
        run_random(150);
        drain();

        write_cfg(CFG_STATES, 1);
        write_cfg(CFG_CONTROLS, 1);
        send_idle = 47;
        run_random(150);
        drain();

        write_cfg(CFG_STATES, 3);
        write_cfg(CFG_CONTROLS, 0);
        send_idle = 0;
        recv_stall = 47;
        run_random(150);
        drain();

        write_cfg(CFG_STATES, 32'hFFFF_FFF7);
        write_cfg(CFG_CONTROLS, 3);
        write_cfg(CFG_SPARE, $urandom);
        send_idle = 27;
        recv_stall = 27;
        run_random(150);
        drain();

        write_cfg(CFG_STATES, 0);
        write_cfg(CFG_CONTROLS, 2);
        send_idle = 0;
        recv_stall = 0;
        hold_on = 1'b1;
        run_random(150);
        drain();

        write_cfg(CFG_STATES, 4);
        write_cfg(CFG_CONTROLS, 2);
        recv_stall = 20;
        run_random(150);
        drain();

        if (errors == 0 && law_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
